// ===== src/rv32ex_pkg.sv =====
`timescale 1ns / 1ps

package rv32ex_pkg;

    localparam int XLEN = 32;

    // Bit positions inside operand_sel
    localparam int OSEL_IMM_B = 0;
    localparam int OSEL_PC_A  = 1;

    localparam logic [XLEN-1:0] LINK_OFFSET = 32'd4;
    localparam logic [XLEN-1:0] JALR_MASK   = ~32'd1;

    typedef enum logic [3:0] {
        ALU_ADD   = 4'd0,
        ALU_SUB   = 4'd1,
        ALU_SLL   = 4'd2,
        ALU_SLT   = 4'd3,
        ALU_SLTU  = 4'd4,
        ALU_XOR   = 4'd5,
        ALU_SRL   = 4'd6,
        ALU_SRA   = 4'd7,
        ALU_OR    = 4'd8,
        ALU_AND   = 4'd9,
        ALU_PASSB = 4'd10,
        ALU_PASSA = 4'd11
    } alu_op_t;

    typedef enum logic [1:0] {
        KIND_PLAIN  = 2'd0,
        KIND_BRANCH = 2'd1,
        KIND_JAL    = 2'd2,
        KIND_JALR   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        COND_EQ  = 3'd0,
        COND_NE  = 3'd1,
        COND_LT  = 3'd4,
        COND_GE  = 3'd5,
        COND_LTU = 3'd6,
        COND_GEU = 3'd7
    } cond_t;

    typedef enum logic [1:0] {
        FWD_REG   = 2'd0,
        FWD_EXMEM = 2'd1,
        FWD_MEMWB = 2'd2
    } fwd_t;

    typedef struct packed {
        logic [XLEN-1:0] pc;
        logic [XLEN-1:0] rs1_value;
        logic [XLEN-1:0] rs2_value;
        logic [XLEN-1:0] imm;
        logic [XLEN-1:0] exmem_value;
        logic [XLEN-1:0] memwb_value;
        alu_op_t         func;
        logic [1:0]      operand_sel;
        kind_t           control_kind;
        cond_t           branch_cond;
        fwd_t            fwd_a;
        fwd_t            fwd_b;
    } instr_t;

    typedef struct packed {
        logic [XLEN-1:0] opa;
        logic [XLEN-1:0] opb;
    } operands_t;

    typedef struct packed {
        logic            redirect;
        logic            jump;
        logic [XLEN-1:0] target;
        logic [XLEN-1:0] link;
    } flow_t;

    typedef struct packed {
        logic [XLEN-1:0] result_value;
        logic [XLEN-1:0] store_data;
        logic            redirect;
        logic [XLEN-1:0] target;
    } result_t;

endpackage

// ===== src/rv32ex_fwd_mux.sv =====
`timescale 1ns / 1ps

module rv32ex_fwd_mux (
    input  rv32ex_pkg::instr_t    instr,
    input  logic                  forward_enable,
    output rv32ex_pkg::operands_t ops
);

    function automatic logic [rv32ex_pkg::XLEN-1:0] pick(
        input rv32ex_pkg::fwd_t          sel,
        input logic [rv32ex_pkg::XLEN-1:0] reg_val,
        input logic [rv32ex_pkg::XLEN-1:0] exm,
        input logic [rv32ex_pkg::XLEN-1:0] wb
    );
        logic [rv32ex_pkg::XLEN-1:0] v;
        v = reg_val;
        if (forward_enable) begin
            unique case (sel)
                rv32ex_pkg::FWD_EXMEM: v = exm;
                rv32ex_pkg::FWD_MEMWB: v = wb;
                default:               v = reg_val;
            endcase
        end
        return v;
    endfunction

    always_comb begin
        ops.opa = pick(instr.fwd_a, instr.rs1_value, instr.exmem_value, instr.memwb_value);
        ops.opb = pick(instr.fwd_b, instr.rs2_value, instr.exmem_value, instr.memwb_value);
    end

endmodule

// ===== src/rv32ex_alu.sv =====
`timescale 1ns / 1ps

module rv32ex_alu (
    input  rv32ex_pkg::alu_op_t          op,
    input  logic [rv32ex_pkg::XLEN-1:0]  a,
    input  logic [rv32ex_pkg::XLEN-1:0]  b,
    output logic [rv32ex_pkg::XLEN-1:0]  y
);

    localparam int SHW = $clog2(rv32ex_pkg::XLEN);

    logic [SHW-1:0] sh;

    assign sh = b[SHW-1:0];

    always_comb begin
        unique case (op)
            rv32ex_pkg::ALU_ADD:   y = a + b;
            rv32ex_pkg::ALU_SUB:   y = a - b;
            rv32ex_pkg::ALU_SLL:   y = a << sh;
            rv32ex_pkg::ALU_SLT:   y = {{(rv32ex_pkg::XLEN-1){1'b0}}, $signed(a) < $signed(b)};
            rv32ex_pkg::ALU_SLTU:  y = {{(rv32ex_pkg::XLEN-1){1'b0}}, a < b};
            rv32ex_pkg::ALU_XOR:   y = a ^ b;
            rv32ex_pkg::ALU_SRL:   y = a >> sh;
            rv32ex_pkg::ALU_SRA:   y = $unsigned($signed(a) >>> sh);
            rv32ex_pkg::ALU_OR:    y = a | b;
            rv32ex_pkg::ALU_AND:   y = a & b;
            rv32ex_pkg::ALU_PASSB: y = b;
            rv32ex_pkg::ALU_PASSA: y = a;
            default:               y = '0;
        endcase
    end

endmodule

// ===== src/rv32ex_branch.sv =====
`timescale 1ns / 1ps

module rv32ex_branch (
    input  rv32ex_pkg::instr_t    instr,
    input  rv32ex_pkg::operands_t ops,
    output rv32ex_pkg::flow_t     flow
);

    logic taken;

    always_comb begin
        unique case (instr.branch_cond)
            rv32ex_pkg::COND_EQ:  taken = ops.opa == ops.opb;
            rv32ex_pkg::COND_NE:  taken = ops.opa != ops.opb;
            rv32ex_pkg::COND_LT:  taken = $signed(ops.opa) < $signed(ops.opb);
            rv32ex_pkg::COND_GE:  taken = $signed(ops.opa) >= $signed(ops.opb);
            rv32ex_pkg::COND_LTU: taken = ops.opa < ops.opb;
            rv32ex_pkg::COND_GEU: taken = ops.opa >= ops.opb;
            default:              taken = 1'b0;
        endcase
    end

    always_comb begin
        flow.link     = instr.pc + rv32ex_pkg::LINK_OFFSET;
        flow.target   = instr.pc + instr.imm;
        flow.redirect = 1'b0;
        flow.jump     = 1'b0;
        unique case (instr.control_kind)
            rv32ex_pkg::KIND_PLAIN: begin
                flow.redirect = 1'b0;
            end
            rv32ex_pkg::KIND_BRANCH: begin
                flow.redirect = taken;
            end
            rv32ex_pkg::KIND_JAL: begin
                flow.redirect = 1'b1;
                flow.jump     = 1'b1;
            end
            rv32ex_pkg::KIND_JALR: begin
                // base is the forwarded rs1 operand, never the pc
                flow.redirect = 1'b1;
                flow.jump     = 1'b1;
                flow.target   = (ops.opa + instr.imm) & rv32ex_pkg::JALR_MASK;
            end
            default: begin
                flow.redirect = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/rv32i_execute_stage_top.sv =====
`timescale 1ns / 1ps

// RV32I execute stage with operand forwarding.
// Input channel (s_*): one decoded instruction per request, with the
// forwarding sources exmem/memwb captured alongside it.
// Result channel (m_*): ALU or link result, store data, redirect and target.
// Path: a request accepted on s_* passes the input register, then the
// result register, before it shows on m_*.
// Throughput: one request per cycle while m_ready stays high; the single-pass
// ALU/branch logic between the two registers sets this figure.
// Stall: when m_ready is low the result register holds; an empty input
// register still takes one more request, after which s_ready drops until
// the receiver drains the result.
// Reset (aresetn low, synchronous): both stages empty, forward_enable = 1.
// Configuration: cfg_wr_en writes cfg_wr_data into forward_enable at the
// edge; write it only while no request is in flight.
module rv32i_execute_stage_top (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic        [31:0] s_pc,
    input  logic signed [31:0] s_rs1_value,
    input  logic signed [31:0] s_rs2_value,
    input  logic signed [31:0] s_imm,
    input  logic        [3:0]  s_func,
    input  logic        [1:0]  s_operand_sel,
    input  logic        [1:0]  s_control_kind,
    input  logic        [2:0]  s_branch_cond,
    input  logic        [1:0]  s_fwd_a,
    input  logic        [1:0]  s_fwd_b,
    input  logic signed [31:0] s_exmem_value,
    input  logic signed [31:0] s_memwb_value,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_value,
    output logic signed [31:0] m_store_data,
    output logic               m_redirect,
    output logic        [31:0] m_target
);

    logic                       fwd_en_reg;
    logic                       in_valid_reg;
    rv32ex_pkg::instr_t         in_instr_reg;
    rv32ex_pkg::instr_t         in_instr_next;
    logic                       out_valid_reg;
    rv32ex_pkg::result_t        out_result_reg;
    rv32ex_pkg::result_t        out_result_next;

    rv32ex_pkg::operands_t      ops;
    rv32ex_pkg::flow_t          flow;
    logic [rv32ex_pkg::XLEN-1:0] alu_a;
    logic [rv32ex_pkg::XLEN-1:0] alu_b;
    logic [rv32ex_pkg::XLEN-1:0] alu_y;

    logic                       out_load;
    logic                       in_load;

    // Advance the result stage when it is empty or being drained
    assign out_load = !out_valid_reg || m_ready;
    // Take a new request when the input stage is empty or moves on this cycle
    assign in_load  = !in_valid_reg || out_load;
    assign s_ready  = in_load;

    // Pack the request payload
    always_comb begin
        in_instr_next.pc           = s_pc;
        in_instr_next.rs1_value    = s_rs1_value;
        in_instr_next.rs2_value    = s_rs2_value;
        in_instr_next.imm          = s_imm;
        in_instr_next.exmem_value  = s_exmem_value;
        in_instr_next.memwb_value  = s_memwb_value;
        in_instr_next.func         = rv32ex_pkg::alu_op_t'(s_func);
        in_instr_next.operand_sel  = s_operand_sel;
        in_instr_next.control_kind = rv32ex_pkg::kind_t'(s_control_kind);
        in_instr_next.branch_cond  = rv32ex_pkg::cond_t'(s_branch_cond);
        in_instr_next.fwd_a        = rv32ex_pkg::fwd_t'(s_fwd_a);
        in_instr_next.fwd_b        = rv32ex_pkg::fwd_t'(s_fwd_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_en_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            fwd_en_reg <= cfg_wr_data;
        end
    end

    // Input register: hold while the result stage is blocked
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_load) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load && s_valid) begin
            in_instr_reg <= in_instr_next;
        end
    end

    rv32ex_fwd_mux u_fwd (
        .instr          (in_instr_reg),
        .forward_enable (fwd_en_reg),
        .ops            (ops)
    );

    // ALU operand select: pc for auipc, immediate for I-type
    assign alu_a = in_instr_reg.operand_sel[rv32ex_pkg::OSEL_PC_A] ? in_instr_reg.pc : ops.opa;
    assign alu_b = in_instr_reg.operand_sel[rv32ex_pkg::OSEL_IMM_B] ? in_instr_reg.imm : ops.opb;

    rv32ex_alu u_alu (
        .op (in_instr_reg.func),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    rv32ex_branch u_branch (
        .instr (in_instr_reg),
        .ops   (ops),
        .flow  (flow)
    );

    // Jumps return the link address instead of the ALU result
    always_comb begin
        out_result_next.result_value = flow.jump ? flow.link : alu_y;
        out_result_next.store_data   = ops.opb;
        out_result_next.redirect     = flow.redirect;
        out_result_next.target       = flow.target;
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            out_result_reg <= out_result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_value = $signed(out_result_reg.result_value);
    assign m_store_data   = $signed(out_result_reg.store_data);
    assign m_redirect     = out_result_reg.redirect;
    assign m_target       = out_result_reg.target;

endmodule

// ===== src/rv32ex_checker.sv =====
`timescale 1ns / 1ps

module rv32ex_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_result_value,
    input logic [31:0] m_target
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value) && $stable(m_target))
        else $error("result dropped or changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // With the result stage empty, a request can always be taken
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty result stage");

    // An accepted request passes the input register into the result stage when the receiver is ready
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready |=> m_valid)
        else $error("accepted request did not appear on the result channel");

endmodule

bind rv32i_execute_stage_top rv32ex_checker u_rv32ex_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_target       (m_target)
);
